/* design/ecal_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecal_pkg
// Shared constants and the month lookup for the seconds-to-calendar pipeline.
// ----------------------------------------------------------------------------
package ecal_pkg;

  localparam int IN_W  = 40;
  localparam int OUT_W = 56;
  localparam int LAT   = 12;

  // seconds per day is 2^7 * 675: the power of two is split off first
  localparam int          SEC_LO_BITS = 7;
  localparam int unsigned SEC_DAY_ODD = 675;

  localparam logic [23:0] DAY0_1970   = 24'd719162;
  localparam int unsigned DAYS_400Y   = 146097;
  localparam int unsigned DAYS_100Y   = 36524;
  localparam int unsigned DAYS_4Y     = 1461;
  localparam int unsigned DAYS_YEAR   = 365;
  localparam int unsigned DAYS_WEEK   = 7;
  localparam int unsigned SEC_PER_MIN = 60;

  localparam logic [1:0]  CENT_LAST   = 2'd3;
  localparam logic [4:0]  QUAD_LAST   = 5'd24;
  localparam logic [1:0]  YOFF_LAST   = 2'd3;

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // first day of year of month m, with the leap day counted from march on
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    base = MONTH_START[m];
    if (leap && (m >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

/* design/epoch_seconds_to_calendar_date_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_core
// Converts whole seconds since 1970-01-01 UTC to Gregorian date and time.
//
//   channel  dir  width  contents
//   in_      in   40     epoch_seconds
//   out_     out  56     year, month, day_of_month, weekday, day_of_year,
//                        hour, minute, second
//
// Twelve register stages; one transfer in and one out per cycle when the
// output side keeps taking. The stages are set by the chain of constant
// dividers (days, 400- and 4-year cycles, weekday, minutes, hours).
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [ecal_pkg::IN_W-1:0]  in_tdata,   // [39:0] epoch_seconds
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [ecal_pkg::OUT_W-1:0] out_tdata   // [15:0] year, [19:16] month,
                                                 // [24:20] day_of_month,
                                                 // [27:25] weekday,
                                                 // [36:28] day_of_year,
                                                 // [41:37] hour, [47:42] minute,
                                                 // [53:48] second, [55:54] zero
);

  import ecal_pkg::*;

  localparam logic [17:0] CENT_1 = 18'(DAYS_100Y);
  localparam logic [17:0] CENT_2 = 18'(DAYS_100Y * 2);
  localparam logic [17:0] CENT_3 = 18'(DAYS_100Y * 3);
  localparam logic [10:0] YR_1   = 11'(DAYS_YEAR);
  localparam logic [10:0] YR_2   = 11'(DAYS_YEAR * 2);
  localparam logic [10:0] YR_3   = 11'(DAYS_YEAR * 3);

  logic           adv;
  logic [LAT-1:0] vld_r;

  // stages 1-4: seconds to days and second of day
  logic [15:0] s1_lo_r, s2_lo_r;
  logic [6:0]  s1_r1_r, s2_r1_r, s3_r1_r, s4_r1_r;
  logic [7:0]  qa, s3_qa_r, s4_qa_r;
  logic [9:0]  ra, rb;
  logic [15:0] qb;

  // stage 5
  logic [23:0] tx_r, txp_r;
  logic [16:0] sod_r;

  // stages 6-7
  logic [6:0]  c400;
  logic [17:0] r400;
  logic [2:0]  wk;
  logic [10:0] mins;
  logic [5:0]  sec;

  // stage 8
  logic [1:0]  c100_nxt, c100_r;
  logic [15:0] r100_nxt, r100_r;
  logic [6:0]  s8_c400_r;
  logic [2:0]  s8_wk_r;
  logic [5:0]  s8_sec_r;

  // stages 9-10
  logic [6:0]  s9_c400_r, s10_c400_r;
  logic [1:0]  s9_c100_r, s10_c100_r;
  logic [2:0]  s9_wk_r, s10_wk_r;
  logic [5:0]  s9_sec_r, s10_sec_r;
  logic [4:0]  hour, s10_hour_r;
  logic [5:0]  minute, s10_min_r;
  logic [4:0]  c4;
  logic [10:0] r4;

  // stage 11
  logic [1:0]  yoff;
  logic [8:0]  doy_nxt, doy_r;
  logic [15:0] year_nxt, year_r;
  logic        leap_nxt, leap_r;
  logic [2:0]  s11_wk_r;
  logic [5:0]  s11_sec_r, s11_min_r;
  logic [4:0]  s11_hour_r;

  // stage 12, output register
  logic [3:0]  mon_nxt;
  logic [8:0]  mbase;
  logic [4:0]  dom_nxt;
  logic [15:0] o_year_r;
  logic [3:0]  o_mon_r;
  logic [4:0]  o_dom_r;
  logic [2:0]  o_wk_r;
  logic [8:0]  o_doy_r;
  logic [4:0]  o_hour_r;
  logic [5:0]  o_min_r;
  logic [5:0]  o_sec_r;

  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // high part of (seconds >> 7) divided by 675
  ecal_cdiv #(.XW(17), .QW(8), .RW(10), .D(SEC_DAY_ODD), .K(17)) u_div_hi (
    .clk (clk), .en (adv),
    .x   (in_tdata[IN_W-1:SEC_LO_BITS+16]),
    .q   (qa), .r (ra)
  );

  // remainder joined with the low 16 bits, divided by 675 again
  ecal_cdiv #(.XW(26), .QW(16), .RW(10), .D(SEC_DAY_ODD), .K(26)) u_div_lo (
    .clk (clk), .en (adv),
    .x   ({ra, s2_lo_r}),
    .q   (qb), .r (rb)
  );

  ecal_cdiv #(.XW(24), .QW(7), .RW(18), .D(DAYS_400Y), .K(24)) u_div_400 (
    .clk (clk), .en (adv), .x (tx_r), .q (c400), .r (r400)
  );

  // day 0 of the linear count is a monday, so tx + 1 gives sunday as 0
  ecal_cdiv #(.XW(24), .QW(22), .RW(3), .D(DAYS_WEEK), .K(24)) u_div_wk (
    .clk (clk), .en (adv), .x (txp_r), .q (), .r (wk)
  );

  ecal_cdiv #(.XW(17), .QW(11), .RW(6), .D(SEC_PER_MIN), .K(17)) u_div_sec (
    .clk (clk), .en (adv), .x (sod_r), .q (mins), .r (sec)
  );

  ecal_cdiv #(.XW(11), .QW(5), .RW(6), .D(SEC_PER_MIN), .K(11)) u_div_min (
    .clk (clk), .en (adv), .x (mins), .q (hour), .r (minute)
  );

  ecal_cdiv #(.XW(16), .QW(5), .RW(11), .D(DAYS_4Y), .K(16)) u_div_4y (
    .clk (clk), .en (adv), .x (r100_r), .q (c4), .r (r4)
  );

  // century index, capped so the last day of 400 years stays in the last century
  always_comb begin
    if (r400 >= CENT_3) begin
      c100_nxt = 2'd3;
      r100_nxt = 16'(r400 - CENT_3);
    end else if (r400 >= CENT_2) begin
      c100_nxt = 2'd2;
      r100_nxt = 16'(r400 - CENT_2);
    end else if (r400 >= CENT_1) begin
      c100_nxt = 2'd1;
      r100_nxt = 16'(r400 - CENT_1);
    end else begin
      c100_nxt = 2'd0;
      r100_nxt = 16'(r400);
    end
  end

  // first three years of a four-year group are never leap years
  always_comb begin
    if (r4 >= YR_3) begin
      yoff    = 2'd3;
      doy_nxt = 9'(r4 - YR_3);
    end else if (r4 >= YR_2) begin
      yoff    = 2'd2;
      doy_nxt = 9'(r4 - YR_2);
    end else if (r4 >= YR_1) begin
      yoff    = 2'd1;
      doy_nxt = 9'(r4 - YR_1);
    end else begin
      yoff    = 2'd0;
      doy_nxt = 9'(r4);
    end
    year_nxt = 16'(s10_c400_r) * 16'd400 + 16'(s10_c100_r) * 16'd100
             + 16'(c4) * 16'd4 + 16'(yoff) + 16'd1;
    leap_nxt = (yoff == YOFF_LAST) && ((c4 != QUAD_LAST) || (s10_c100_r == CENT_LAST));
  end

  always_comb begin
    mon_nxt = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy_r >= month_start(4'(m), leap_r)) begin
        mon_nxt = 4'(m);
      end
    end
    mbase   = month_start(mon_nxt, leap_r);
    dom_nxt = 5'(doy_r - mbase) + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lo_r    <= in_tdata[SEC_LO_BITS+15:SEC_LO_BITS];
      s1_r1_r    <= in_tdata[SEC_LO_BITS-1:0];
      s2_lo_r    <= s1_lo_r;
      s2_r1_r    <= s1_r1_r;
      s3_qa_r    <= qa;
      s3_r1_r    <= s2_r1_r;
      s4_qa_r    <= s3_qa_r;
      s4_r1_r    <= s3_r1_r;

      tx_r       <= {s4_qa_r, qb} + DAY0_1970;
      txp_r      <= {s4_qa_r, qb} + DAY0_1970 + 24'd1;
      sod_r      <= {rb, s4_r1_r};

      c100_r     <= c100_nxt;
      r100_r     <= r100_nxt;
      s8_c400_r  <= c400;
      s8_wk_r    <= wk;
      s8_sec_r   <= sec;

      s9_c400_r  <= s8_c400_r;
      s9_c100_r  <= c100_r;
      s9_wk_r    <= s8_wk_r;
      s9_sec_r   <= s8_sec_r;

      s10_c400_r <= s9_c400_r;
      s10_c100_r <= s9_c100_r;
      s10_wk_r   <= s9_wk_r;
      s10_sec_r  <= s9_sec_r;
      s10_hour_r <= hour;
      s10_min_r  <= minute;

      year_r     <= year_nxt;
      doy_r      <= doy_nxt;
      leap_r     <= leap_nxt;
      s11_wk_r   <= s10_wk_r;
      s11_sec_r  <= s10_sec_r;
      s11_min_r  <= s10_min_r;
      s11_hour_r <= s10_hour_r;

      o_year_r   <= year_r;
      o_mon_r    <= mon_nxt;
      o_dom_r    <= dom_nxt;
      o_wk_r     <= s11_wk_r;
      o_doy_r    <= doy_r;
      o_hour_r   <= s11_hour_r;
      o_min_r    <= s11_min_r;
      o_sec_r    <= s11_sec_r;
    end
  end

  assign out_tdata = {2'b00, o_sec_r, o_min_r, o_hour_r, o_doy_r,
                      o_wk_r, o_dom_r, o_mon_r, o_year_r};

endmodule

/* design/ecal_cdiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecal_cdiv
// Two-stage division by a constant: reciprocal multiply, then one correction.
// ----------------------------------------------------------------------------
module ecal_cdiv #(
  parameter int          XW = 16,
  parameter int          QW = 8,
  parameter int          RW = 8,
  parameter int unsigned D  = 3,
  parameter int          K  = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  output logic [QW-1:0] q,
  output logic [RW-1:0] r
);

  // floor reciprocal: estimate is the quotient or one short of it while x < 2^K
  localparam int unsigned     MUL   = (32'd1 << K) / D;
  localparam int              MW    = $clog2(MUL + 1);
  localparam int              PW    = XW + MW;
  localparam logic [MW-1:0]   MUL_V = MW'(MUL);
  localparam logic [XW-1:0]   DIV_V = XW'(D);

  logic [PW-1:0] prod;
  logic [QW-1:0] qe_nxt;
  logic [QW-1:0] qe_r;
  logic [XW-1:0] x_r;
  logic [XW-1:0] diff;
  logic [QW-1:0] q_nxt;
  logic [RW-1:0] r_nxt;
  logic [QW-1:0] q_r;
  logic [RW-1:0] r_r;

  assign prod   = PW'(x) * PW'(MUL_V);
  assign qe_nxt = QW'(prod >> K);

  always_comb begin
    diff = x_r - XW'(qe_r) * DIV_V;
    if (diff >= DIV_V) begin
      q_nxt = qe_r + QW'(1);
      r_nxt = RW'(diff - DIV_V);
    end else begin
      q_nxt = qe_r;
      r_nxt = RW'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x;
      qe_r <= qe_nxt;
      q_r  <= q_nxt;
      r_r  <= r_nxt;
    end
  end

  assign q = q_r;
  assign r = r_r;

endmodule
